// ===== hdl/dptt_pkg.sv =====
`timescale 1ns / 1ps

package dptt_pkg;

    // Item kinds
    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Stored score kinds
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    // Position key width and key bits folded per residue step
    localparam int KEY_BITS  = 64;
    localparam int RES_DIGIT = 4;

    // Generation mark kept with each slot; a wrap forces a clearing sweep
    localparam int EPOCH_BITS = 4;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]          kind;
        logic [63:0]         position_key;
        logic [7:0]          search_depth;
        logic signed [15:0]  alpha;
        logic signed [15:0]  beta;
        logic signed [15:0]  new_score;
        logic [1:0]          bound_kind;
        logic [4:0]          move_hole;
        logic [1:0]          move_color;
    } in_word_t;

    typedef struct packed {
        logic                hit;
        logic                usable;
        logic [7:0]          found_depth;
        logic signed [15:0]  found_score;
        logic [1:0]          found_bound;
        logic [4:0]          found_hole;
        logic [1:0]          found_color;
        logic                stored;
        logic [31:0]         hit_count;
        logic [31:0]         miss_count;
        logic [31:0]         collision_count;
    } out_word_t;

endpackage

// ===== hdl/dptt_ram.sv =====
`timescale 1ns / 1ps

module dptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/dptt_fifo.sv =====
`timescale 1ns / 1ps

module dptt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold pushed words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hdl/dptt_front.sv =====
`timescale 1ns / 1ps

module dptt_front #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  dptt_pkg::in_word_t               item,
    output logic                             ready,
    output logic                             q_push,
    output dptt_pkg::in_word_t               q_item,
    output logic [$clog2(TABLE_ENTRIES)-1:0] q_idx,
    input  logic                             q_full
);

    localparam int  IDX_W   = $clog2(TABLE_ENTRIES);
    localparam bit  IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    localparam int  STEPS   = dptt_pkg::KEY_BITS / dptt_pkg::RES_DIGIT;
    localparam int  STEP_W  = $clog2(STEPS + 1);

    logic                          busy_reg;
    dptt_pkg::in_word_t            item_reg;
    logic [dptt_pkg::KEY_BITS-1:0] key_sh_reg;
    logic [IDX_W-1:0]              resid_reg, resid_next;
    logic [STEP_W-1:0]             step_reg;
    logic                          done;
    logic [IDX_W:0]                part;

    assign done   = IS_POW2 ? 1'b1 : (step_reg == STEP_W'(STEPS));
    assign q_push = busy_reg && done && !q_full;
    assign ready  = !busy_reg || q_push;
    assign q_item = item_reg;
    assign q_idx  = IS_POW2 ? item_reg.position_key[IDX_W-1:0] : resid_reg;

    // Fold the next key digit into the residue, MSB first
    always_comb
    begin
        part       = '0;
        resid_next = resid_reg;
        for (int j = 0; j < dptt_pkg::RES_DIGIT; j++)
        begin
            part = {resid_next, key_sh_reg[dptt_pkg::KEY_BITS - 1 - j]};
            if (part >= (IDX_W+1)'(TABLE_ENTRIES))
            begin
                part = part - (IDX_W+1)'(TABLE_ENTRIES);
            end
            resid_next = part[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (take)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg && !done)
        begin
            step_reg <= step_reg + 1'b1;
        end
        else if (q_push)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Load the word, then shift the key through the residue unit
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg   <= item;
            key_sh_reg <= item.position_key;
            resid_reg  <= '0;
        end
        else if (busy_reg && !done)
        begin
            key_sh_reg <= key_sh_reg << dptt_pkg::RES_DIGIT;
            resid_reg  <= resid_next;
        end
    end

endmodule

// ===== hdl/dptt_back.sv =====
`timescale 1ns / 1ps

module dptt_back #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int DEPTH_BITS    = 8,
    parameter int SCORE_BITS    = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  dptt_pkg::in_word_t               q_item,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] q_idx,
    output logic                             q_pop,
    output dptt_pkg::out_word_t              result,
    output logic                             empty,
    input  logic                             pop,
    output logic                             sweeping
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef struct packed {
        logic                           valid;
        logic [dptt_pkg::EPOCH_BITS-1:0] epoch;
        logic [63:0]                    key;
        logic [DEPTH_BITS-1:0]          depth;
        logic signed [SCORE_BITS-1:0]   score;
        logic [1:0]                     bound;
        logic [4:0]                     hole;
        logic [1:0]                     color;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                sweep_cnt_reg, sweep_cnt_next;
    logic [dptt_pkg::EPOCH_BITS-1:0] epoch_reg, epoch_next;
    dptt_pkg::in_word_t              cur_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [31:0]                     hits_reg, hits_next;
    logic [31:0]                     misses_reg, misses_next;
    logic [31:0]                     colls_reg, colls_next;
    dptt_pkg::out_word_t             res_reg, res_next;
    logic                            res_valid_reg;

    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    entry_t                ram_wr_data;
    logic [ENTRY_W-1:0]    ram_rd_raw;
    entry_t                slot;

    logic                  fire;
    logic                  live, key_eq, probe_hit, store_refuse, usable;
    logic [DEPTH_BITS-1:0] depth_req;
    entry_t                new_entry;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign sweeping = (state_reg == ST_SWEEP);
    assign empty    = !res_valid_reg;
    assign result   = res_reg;
    assign fire     = (state_reg == ST_LOOK) && (!res_valid_reg || pop);
    assign slot     = entry_t'(ram_rd_raw);

    dptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ENTRY_W'(ram_wr_data)),
        .rd_en   (q_pop),
        .rd_addr (q_idx),
        .rd_data (ram_rd_raw)
    );

    // Classify the slot against the current word
    always_comb
    begin
        depth_req    = DEPTH_BITS'(cur_reg.search_depth);
        live         = slot.valid && (slot.epoch == epoch_reg);
        key_eq       = (slot.key == cur_reg.position_key);
        probe_hit    = live && key_eq && !(slot.depth < depth_req);
        store_refuse = live && !key_eq && (slot.depth > depth_req);
        case (slot.bound)
            dptt_pkg::BOUND_EXACT: usable = 1'b1;
            dptt_pkg::BOUND_LOWER:
                usable = $signed(33'(slot.score)) >= $signed(33'(cur_reg.beta));
            dptt_pkg::BOUND_UPPER:
                usable = $signed(33'(slot.score)) <= $signed(33'(cur_reg.alpha));
            default: usable = 1'b0;
        endcase
        new_entry.valid = 1'b1;
        new_entry.epoch = epoch_reg;
        new_entry.key   = cur_reg.position_key;
        new_entry.depth = depth_req;
        new_entry.score = SCORE_BITS'(cur_reg.new_score);
        new_entry.bound = cur_reg.bound_kind;
        new_entry.hole  = cur_reg.move_hole;
        new_entry.color = cur_reg.move_color;
    end

    // Carry out the word: slot write, counters, result; also run the clearing sweep
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        epoch_next     = epoch_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        colls_next     = colls_reg;
        res_next       = '0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_reg;
        ram_wr_data    = new_entry;
        case (state_reg)
            ST_SWEEP:
            begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = sweep_cnt_reg;
                ram_wr_data    = '0;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    sweep_cnt_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                    case (cur_reg.kind)
                        dptt_pkg::KIND_PROBE:
                        begin
                            if (probe_hit)
                            begin
                                hits_next = (hits_reg == dptt_pkg::CNT_MAX) ?
                                            hits_reg : hits_reg + 1'b1;
                                res_next.hit         = 1'b1;
                                res_next.usable      = usable;
                                res_next.found_depth = 8'(slot.depth);
                                res_next.found_score = 16'(slot.score);
                                res_next.found_bound = slot.bound;
                                res_next.found_hole  = slot.hole;
                                res_next.found_color = slot.color;
                            end
                            else
                            begin
                                misses_next = (misses_reg == dptt_pkg::CNT_MAX) ?
                                              misses_reg : misses_reg + 1'b1;
                            end
                        end
                        dptt_pkg::KIND_STORE:
                        begin
                            if (store_refuse)
                            begin
                                colls_next = (colls_reg == dptt_pkg::CNT_MAX) ?
                                             colls_reg : colls_reg + 1'b1;
                            end
                            else
                            begin
                                ram_wr_en       = 1'b1;
                                res_next.stored = 1'b1;
                            end
                        end
                        dptt_pkg::KIND_CLEAR:
                        begin
                            hits_next   = '0;
                            misses_next = '0;
                            colls_next  = '0;
                            epoch_next  = epoch_reg + 1'b1;
                            if (epoch_reg == '1)
                            begin
                                state_next = ST_SWEEP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.hit_count       = hits_next;
                    res_next.miss_count      = misses_next;
                    res_next.collision_count = colls_next;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            epoch_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            colls_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            epoch_reg     <= epoch_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            colls_reg     <= colls_next;
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the popped word and the finished result
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
            idx_reg <= q_idx;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== hdl/depth_preferred_transposition_table.sv =====
`timescale 1ns / 1ps
// A taken word enters the front, which for a non-power-of-two table folds the 64-bit key
// into the slot index, 4 bits per step; it then passes a two-entry queue to the back, which
// reads the slot, then for an accepted store writes it on the table RAM as it registers the
// result. The back takes one word at a time and holds while a result waits to be popped; the
// front can take a new word as it hands its last one on. Every 16th clear wraps the generation
// mark and adds a sweep of every slot. Reset runs the same sweep, full stays high during any sweep.

module depth_preferred_transposition_table #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int DEPTH_BITS    = 8,
    parameter int SCORE_BITS    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dptt_pkg::in_word_t  item,
    output logic                full,
    input  logic                pop,
    output dptt_pkg::out_word_t result,
    output logic                empty
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int QW    = $bits(dptt_pkg::in_word_t) + IDX_W;

    logic               front_ready;
    logic               sweeping;
    logic               take;
    logic               q_push, q_full, q_pop, q_empty;
    dptt_pkg::in_word_t f_item, q_item;
    logic [IDX_W-1:0]   f_idx, q_idx;
    logic [QW-1:0]      q_dout;

    assign full   = !front_ready || sweeping;
    assign take   = push && !full;
    assign q_item = dptt_pkg::in_word_t'(q_dout[QW-1:IDX_W]);
    assign q_idx  = q_dout[IDX_W-1:0];

    dptt_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .ready  (front_ready),
        .q_push (q_push),
        .q_item (f_item),
        .q_idx  (f_idx),
        .q_full (q_full)
    );

    dptt_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_item, f_idx}),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    dptt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .DEPTH_BITS    (DEPTH_BITS),
        .SCORE_BITS    (SCORE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_idx    (q_idx),
        .q_pop    (q_pop),
        .result   (result),
        .empty    (empty),
        .pop      (pop),
        .sweeping (sweeping)
    );

    // Front never pushes into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("front pushed into full queue");

    // Back never pops an empty queue
    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("back popped empty queue");

    // No word leaves the queue during a clearing sweep
    a_sweep_hold: assert property (@(posedge clk) disable iff (!rst_n) sweeping |-> !q_pop)
        else $error("queue popped during sweep");

endmodule
